>>> hw/rtl/assert_macros.svh
// Assertion helpers, clocked on the rising edge and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define VBB_CHECK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication.
`define VBB_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define VBB_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/vbb_pkg.sv
package vbb_pkg;

  localparam int GRID_SIZE  = 16;
  localparam int EW         = $clog2(GRID_SIZE + 1);
  localparam int CW         = $clog2(GRID_SIZE);
  localparam int PLEN_MAX   = GRID_SIZE * GRID_SIZE - 2 * GRID_SIZE - 1;
  localparam int RING_DEPTH = (PLEN_MAX > GRID_SIZE) ? PLEN_MAX : GRID_SIZE;
  localparam int RAW        = $clog2(RING_DEPTH);
  localparam int RLW        = $clog2(RING_DEPTH + 1);
  localparam int NCOL       = 9;

  localparam int LSW = 18;  // three taps
  localparam int PSW = 20;  // nine taps
  localparam int TSW = 21;  // 27 taps

  // floor(s / 27) == (s * RECIP_K) >> RECIP_SH for s < 2**21
  localparam int RECIP_SH = 26;
  localparam logic [21:0] RECIP_K = 22'd2485514;
  localparam logic [8:0] ALPHA_ONE = 9'd256;

  typedef logic [3:0][15:0] vox_t;       // [0] red .. [3] alpha
  typedef logic [3:0][LSW-1:0] lsum_t;
  typedef logic [3:0][PSW-1:0] psum_t;
  typedef logic [3:0][TSW-1:0] tsum_t;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
    logic        flush;
  } in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [8:0]  alpha_out;
    logic [11:0] voxel_index;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [11:0] voxel_index;
    logic        last;
  } meta_t;

  typedef struct packed {
    meta_t      m;
    logic [2:0] xm;
    logic [2:0] ym;
    logic [2:0] zm;
  } s1meta_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } xyz_t;

endpackage

>>> hw/rtl/vbb_ring.sv
module vbb_ring (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     clr_i,
  input  logic [vbb_pkg::RLW-1:0]  len_i,
  input  vbb_pkg::vox_t            din_i,
  output vbb_pkg::vox_t            dout_o
);

  vbb_pkg::vox_t mem_q [vbb_pkg::RING_DEPTH];
  vbb_pkg::vox_t dout_q;
  logic [vbb_pkg::RAW-1:0] ptr_q, ptr_d;

  always_comb begin
    ptr_d = ptr_q;
    if (clr_i) begin
      ptr_d = '0;
    end else if (en_i) begin
      if (vbb_pkg::RLW'(ptr_q) + vbb_pkg::RLW'(1) == len_i) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + vbb_pkg::RAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // read before write: output is the sample from len_i items back
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dout_q        <= mem_q[ptr_q];
      mem_q[ptr_q]  <= din_i;
    end
  end

  assign dout_o = dout_q;

endmodule

>>> hw/rtl/vbb_lane.sv
module vbb_lane (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           col_en_i,
  input  logic [2:0]     z_en_i,
  input  vbb_pkg::vox_t  tap_i [3],
  output vbb_pkg::lsum_t sum_o
);

  vbb_pkg::lsum_t sum_q, sum_d;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_d[c] = '0;
      for (int k = 0; k < 3; k++) begin
        if (col_en_i && z_en_i[k]) begin
          sum_d[c] = sum_d[c] + vbb_pkg::LSW'(tap_i[k][c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> hw/rtl/vbb_merge.sv
module vbb_merge (
  input  logic            clk_i,
  input  logic            en3_i,
  input  logic            en4_i,
  input  logic            eno_i,
  input  vbb_pkg::lsum_t  lsum_i [vbb_pkg::NCOL],
  input  vbb_pkg::meta_t  meta_i,
  output vbb_pkg::out_t   out_o
);

  vbb_pkg::psum_t p3_q [3];
  vbb_pkg::psum_t p3_d [3];
  vbb_pkg::tsum_t s4_q, s4_d;
  vbb_pkg::meta_t m3_q, m4_q;
  vbb_pkg::out_t  out_q, out_d;
  logic [42:0]    prod [3];

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      for (int c = 0; c < 4; c++) begin
        p3_d[g][c] = vbb_pkg::PSW'(lsum_i[3*g][c]) + vbb_pkg::PSW'(lsum_i[3*g+1][c])
                   + vbb_pkg::PSW'(lsum_i[3*g+2][c]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      s4_d[c] = vbb_pkg::TSW'(p3_q[0][c]) + vbb_pkg::TSW'(p3_q[1][c])
              + vbb_pkg::TSW'(p3_q[2][c]);
    end
  end

  // divide the colour sums by 27 through the reciprocal; alpha is ALPHA_ONE if its sum is nonzero
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = 43'(s4_q[c]) * 43'(vbb_pkg::RECIP_K);
    end
    out_d.red_out     = prod[0][vbb_pkg::RECIP_SH+15:vbb_pkg::RECIP_SH];
    out_d.green_out   = prod[1][vbb_pkg::RECIP_SH+15:vbb_pkg::RECIP_SH];
    out_d.blue_out    = prod[2][vbb_pkg::RECIP_SH+15:vbb_pkg::RECIP_SH];
    out_d.alpha_out   = (s4_q[3] != '0) ? vbb_pkg::ALPHA_ONE : '0;
    out_d.voxel_index = m4_q.voxel_index;
    out_d.last        = m4_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      p3_q <= p3_d;
      m3_q <= meta_i;
    end
    if (en4_i) begin
      s4_q <= s4_d;
      m4_q <= m3_q;
    end
    if (eno_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

>>> hw/rtl/voxel_box_blur_3d_core.sv
// Channel   Dir  Handshake                Payload
// in        in   in_valid_i / in_stall_o  in_data_i  (vbb_pkg::in_t)
// out       out  out_valid_o / out_stall_i out_data_o (vbb_pkg::out_t)
// cfg       in   cfg_we_i                 cfg_wdata_i (grid edge, 5 bits)
//
// One item per cycle sustained while the output is not stalled; the 27 taps come
// at once from eight delay rings (one memory each), the column tail registers and
// the item register, so the rings' single port sets the rate. The item completing a
// neighborhood yields a result via lane sums, plane sums, total, then output register.
// Reset clears positions, ring pointers and pipeline valids; history memory is not
// cleared, since out-of-grid taps are masked and in-grid taps are always written.
// A stall on the output holds each full stage; input stalls only once all five are
// full and the output is stalled.

`include "assert_macros.svh"

module voxel_box_blur_3d_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vbb_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output vbb_pkg::out_t    out_data_o,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_wdata_i
);

  localparam int EW  = vbb_pkg::EW;
  localparam int RLW = vbb_pkg::RLW;

  // coordinate step, z innermost
  function automatic vbb_pkg::xyz_t adv(vbb_pkg::xyz_t p, logic [EW-1:0] em1);
    vbb_pkg::xyz_t r;
    r = p;
    if (EW'(p.z) == em1) begin
      r.z = '0;
      if (EW'(p.y) == em1) begin
        r.y = '0;
        r.x = p.x + vbb_pkg::CW'(1);
      end else begin
        r.y = p.y + vbb_pkg::CW'(1);
      end
    end else begin
      r.z = p.z + vbb_pkg::CW'(1);
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [EW-1:0]  grid_q, grid_d;   // edge in use, saturated
  logic [RLW-1:0] plen_q, plen_d;   // plane ring length: E*E - 2E - 1

  always_comb begin
    if (int'(cfg_wdata_i) < 3) begin
      grid_d = EW'(3);
    end else if (int'(cfg_wdata_i) > vbb_pkg::GRID_SIZE) begin
      grid_d = EW'(vbb_pkg::GRID_SIZE);
    end else begin
      grid_d = EW'(cfg_wdata_i);
    end
    plen_d = RLW'(int'(grid_d) * int'(grid_d) - 2 * int'(grid_d) - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= EW'(vbb_pkg::GRID_SIZE);
      plen_q <= RLW'(vbb_pkg::PLEN_MAX);
    end else if (cfg_we_i) begin
      grid_q <= grid_d;
      plen_q <= plen_d;
    end
  end

  logic [EW-1:0] em1;
  assign em1 = grid_q - EW'(1);

  // ---------------- pipeline control ----------------
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;

  assign rdy_o = !vo_q || !out_stall_i;
  assign rdy4  = !v4_q || rdy_o;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = vo_q;

  // ---------------- stream positions ----------------
  vbb_pkg::xyz_t ip_q, ip_d, op_q, op_d;
  logic          done_q, done_d;   // whole grid taken in
  logic          on_q, on_d;       // outputs flowing
  logic [11:0]   idx_q, idx_d;

  logic accept, work, v_zero, at_lag, emit, in_last, out_last;
  vbb_pkg::vox_t word;

  assign accept   = in_valid_i && !in_stall_o;
  assign v_zero   = (ip_q == '0) && !done_q;
  // an idle flush does nothing
  assign work     = accept && !(in_data_i.flush && v_zero);
  // the item at (1,1,1) completes the first neighborhood
  assign at_lag   = !done_q && (ip_q.x == vbb_pkg::CW'(1)) && (ip_q.y == vbb_pkg::CW'(1))
                    && (ip_q.z == vbb_pkg::CW'(1));
  assign emit     = on_q || at_lag;
  assign in_last  = (EW'(ip_q.x) == em1) && (EW'(ip_q.y) == em1) && (EW'(ip_q.z) == em1);
  assign out_last = (EW'(op_q.x) == em1) && (EW'(op_q.y) == em1) && (EW'(op_q.z) == em1);
  // early flush and anything past the grid enter as zero
  assign word     = (in_data_i.flush || done_q) ? '0
                  : {in_data_i.alpha_in, in_data_i.blue_in, in_data_i.green_in,
                     in_data_i.red_in};

  always_comb begin
    ip_d   = ip_q;
    op_d   = op_q;
    done_d = done_q;
    on_d   = on_q;
    idx_d  = idx_q;
    if (cfg_we_i) begin
      ip_d   = '0;
      op_d   = '0;
      done_d = 1'b0;
      on_d   = 1'b0;
      idx_d  = '0;
    end else if (work) begin
      if (emit && out_last) begin
        // grid end: start over
        ip_d   = '0;
        op_d   = '0;
        done_d = 1'b0;
        on_d   = 1'b0;
        idx_d  = '0;
      end else begin
        if (!done_q) begin
          ip_d = adv(ip_q, em1);
          if (in_last) begin
            done_d = 1'b1;
          end
        end
        if (at_lag) begin
          on_d = 1'b1;
        end
        if (emit) begin
          op_d  = adv(op_q, em1);
          idx_d = idx_q + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q   <= '0;
      op_q   <= '0;
      done_q <= 1'b0;
      on_q   <= 1'b0;
      idx_q  <= '0;
    end else begin
      ip_q   <= ip_d;
      op_q   <= op_d;
      done_q <= done_d;
      on_q   <= on_d;
      idx_q  <= idx_d;
    end
  end

  // ---------------- window: rings and z taps ----------------
  // column j = 3*a + b lags the stream by a planes and b rows
  vbb_pkg::vox_t   cur_q;
  vbb_pkg::vox_t   head [vbb_pkg::NCOL];
  vbb_pkg::vox_t   tail_q [vbb_pkg::NCOL][2];
  logic [RLW-1:0]  rlen [1:8];
  logic [RLW-1:0]  row_len, row1_len;

  assign row_len  = RLW'(grid_q);
  assign row1_len = RLW'(em1);

  // first ring takes the fresh item, later ones the previous ring's output
  assign rlen[1] = row_len;
  assign rlen[2] = row1_len;
  assign rlen[3] = plen_q;
  assign rlen[4] = row1_len;
  assign rlen[5] = row1_len;
  assign rlen[6] = plen_q;
  assign rlen[7] = row1_len;
  assign rlen[8] = row1_len;

  assign head[0] = cur_q;

  for (genvar j = 1; j < vbb_pkg::NCOL; j++) begin : g_ring
    vbb_pkg::vox_t din;
    assign din = (j == 1) ? word : head[(j == 1) ? 0 : j - 1];
    vbb_ring u_ring (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (work),
      .clr_i  (cfg_we_i),
      .len_i  (rlen[j]),
      .din_i  (din),
      .dout_o (head[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      cur_q <= word;
      for (int j = 0; j < vbb_pkg::NCOL; j++) begin
        tail_q[j][0] <= head[j];
        tail_q[j][1] <= tail_q[j][0];
      end
    end
  end

  // ---------------- stage 1 meta: edge masks of the output voxel ----------------
  vbb_pkg::s1meta_t s1_q, s1_d;
  vbb_pkg::meta_t   m2_q;

  always_comb begin
    s1_d.m.voxel_index = idx_q;
    s1_d.m.last        = out_last;
    // bit 0: +1 neighbor, bit 1: center, bit 2: -1 neighbor
    s1_d.xm = {op_q.x != '0, 1'b1, EW'(op_q.x) != em1};
    s1_d.ym = {op_q.y != '0, 1'b1, EW'(op_q.y) != em1};
    s1_d.zm = {op_q.z != '0, 1'b1, EW'(op_q.z) != em1};
  end

  always_ff @(posedge clk_i) begin
    if (work && emit) begin
      s1_q <= s1_d;
    end
    if (v1_q && rdy2) begin
      m2_q <= s1_q.m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= work && emit;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy4)  v4_q <= v3_q;
      if (rdy_o) vo_q <= v4_q;
    end
  end

  // ---------------- lanes: one per column ----------------
  vbb_pkg::lsum_t lsum [vbb_pkg::NCOL];

  for (genvar j = 0; j < vbb_pkg::NCOL; j++) begin : g_lane
    vbb_pkg::vox_t taps [3];
    assign taps[0] = head[j];
    assign taps[1] = tail_q[j][0];
    assign taps[2] = tail_q[j][1];
    vbb_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (v1_q && rdy2),
      .col_en_i (s1_q.xm[j/3] && s1_q.ym[j%3]),
      .z_en_i   (s1_q.zm),
      .tap_i    (taps),
      .sum_o    (lsum[j])
    );
  end

  // ---------------- merge, divide and output register ----------------
  vbb_merge u_merge (
    .clk_i  (clk_i),
    .en3_i  (v2_q && rdy3),
    .en4_i  (v3_q && rdy4),
    .eno_i  (v4_q && rdy_o),
    .lsum_i (lsum),
    .meta_i (m2_q),
    .out_o  (out_data_o)
  );

  // ---------------- checks ----------------
  `VBB_IMPLY(a_stall_full, clk_i, rst_ni, in_stall_o, v1_q && v2_q && v3_q && v4_q && vo_q, "input stalled with a free stage")
  `VBB_NEXT(a_grid_end, clk_i, rst_ni, work && emit && out_last, !on_q && !done_q && (ip_q == '0), "positions not cleared after last voxel")
  `VBB_IMPLY(a_alpha_code, clk_i, rst_ni, out_valid_o, out_data_o.alpha_out == '0 || out_data_o.alpha_out == vbb_pkg::ALPHA_ONE, "alpha not zero or one")

endmodule
